### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define APT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Types and constants of the affine point transform.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COEF_W   = 32;
  localparam int NUM_ROWS = 4;
  localparam int LIN_ROWS = 3;
  localparam int NUM_COLS = 3;
  localparam int NUM_COEF = NUM_ROWS * NUM_COLS;
  localparam int NUM_PROD = LIN_ROWS * NUM_COLS;
  localparam int ROW_W    = 2;
  localparam int COL_W    = 2;
  localparam int IDX_W    = $clog2(NUM_COEF);

  localparam int PROD_W = 2 * COEF_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int PSUM_W = TERM_W + 2;
  localparam int SUM_W  = PSUM_W + 1;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [COEF_W-1:0]  value;
  } coef_wr_t;

  typedef struct packed {
    logic [NUM_PROD-1:0][PROD_W-1:0] prod;
    logic [NUM_COLS-1:0][COEF_W-1:0] trans;
  } prod_beat_t;

  typedef struct packed {
    logic [NUM_COLS-1:0][PSUM_W-1:0] psum;
    logic [NUM_COLS-1:0][COEF_W-1:0] trans;
  } psum_beat_t;

endpackage

### rtl/apt_if.sv
// ----------------------------------------------------------------------------
// apt_in_if / apt_out_if
// Valid/ready channels of the affine point transform.
// ----------------------------------------------------------------------------
interface apt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [apt_pkg::ROW_W-1:0]  coef_row;
  logic [apt_pkg::COL_W-1:0]  coef_col;
  logic signed [31:0]         coef_value;
  logic signed [31:0]         point_x;
  logic signed [31:0]         point_y;
  logic signed [31:0]         point_z;

  modport source (
    output valid, op, coef_row, coef_col, coef_value, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, op, coef_row, coef_col, coef_value, point_x, point_y, point_z,
    output ready
  );
endinterface

interface apt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               overflow;

  modport source (
    output valid, out_x, out_y, out_z, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, overflow,
    output ready
  );
endinterface

### rtl/apt_coef_bank.sv
// ----------------------------------------------------------------------------
// apt_coef_bank
// Twelve matrix coefficients, cleared on reset, at most one set per load beat.
// ----------------------------------------------------------------------------
module apt_coef_bank
  import apt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  coef_wr_t wr_i,
  output coef_t    coef_o [NUM_COEF]
);

  coef_t coef_q [NUM_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      coef_q[wr_i.idx] <= coef_t'(wr_i.value);
    end
  end

  assign coef_o = coef_q;

endmodule

### rtl/apt_product_stage.sv
// ----------------------------------------------------------------------------
// apt_product_stage
// Stage one: nine point-by-coefficient products, translation row captured.
// ----------------------------------------------------------------------------
module apt_product_stage
  import apt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  coef_t      point_x_i,
  input  coef_t      point_y_i,
  input  coef_t      point_z_i,
  input  coef_t      coef_i [NUM_COEF],
  output logic       valid_o,
  input  logic       ready_i,
  output prod_beat_t beat_o
);

  logic       valid_q;
  prod_beat_t beat_d, beat_q;
  coef_t      pt [LIN_ROWS];
  logic signed [PROD_W-1:0] prod [NUM_PROD];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    pt[0] = point_x_i;
    pt[1] = point_y_i;
    pt[2] = point_z_i;
    for (int r = 0; r < LIN_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prod[r*NUM_COLS+c] = PROD_W'(pt[r] * coef_i[r*NUM_COLS+c]);
      end
    end
    for (int i = 0; i < NUM_PROD; i++) begin
      beat_d.prod[i] = prod[i];
    end
    for (int c = 0; c < NUM_COLS; c++) begin
      beat_d.trans[c] = coef_i[LIN_ROWS*NUM_COLS+c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

### rtl/apt_accum_stage.sv
// ----------------------------------------------------------------------------
// apt_accum_stage
// Stage two: floor-shift the products and add the three terms of each column.
// ----------------------------------------------------------------------------
module apt_accum_stage
  import apt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  prod_beat_t beat_i,
  output logic       valid_o,
  input  logic       ready_i,
  output psum_beat_t beat_o
);

  logic       valid_q;
  psum_beat_t beat_d, beat_q;
  logic signed [PROD_W-1:0] shifted [NUM_PROD];
  logic signed [TERM_W-1:0] term [NUM_PROD];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int i = 0; i < NUM_PROD; i++) begin
      shifted[i] = $signed(beat_i.prod[i]) >>> FRAC_BITS;
      term[i]    = shifted[i][TERM_W-1:0];
    end
    for (int c = 0; c < NUM_COLS; c++) begin
      beat_d.psum[c] = PSUM_W'(term[c]) + PSUM_W'(term[NUM_COLS+c])
                     + PSUM_W'(term[2*NUM_COLS+c]);
    end
    beat_d.trans = beat_i.trans;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

### rtl/apt_sat_stage.sv
// ----------------------------------------------------------------------------
// apt_sat_stage
// Stage three: add translation, saturate to 32 bits, hold the result beat.
// ----------------------------------------------------------------------------
module apt_sat_stage
  import apt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  psum_beat_t beat_i,
  output logic       valid_o,
  input  logic       ready_i,
  output coef_t      out_x_o,
  output coef_t      out_y_o,
  output coef_t      out_z_o,
  output logic       overflow_o
);

  logic                    valid_q;
  logic signed [SUM_W-1:0] sum [NUM_COLS];
  logic [SUM_W-COEF_W:0]   upper [NUM_COLS];
  coef_t                   res_d [NUM_COLS];
  coef_t                   res_q [NUM_COLS];
  logic [NUM_COLS-1:0]     sat;
  logic                    ovf_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      sum[c]   = SUM_W'($signed(beat_i.psum[c])) + SUM_W'($signed(beat_i.trans[c]));
      upper[c] = sum[c][SUM_W-1:COEF_W-1];
      sat[c]   = !((&upper[c]) || !(|upper[c]));
      if (!sat[c]) begin
        res_d[c] = sum[c][COEF_W-1:0];
      end else if (sum[c][SUM_W-1]) begin
        res_d[c] = SAT_MIN;
      end else begin
        res_d[c] = SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
      ovf_q <= |sat;
    end
  end

  assign valid_o    = valid_q;
  assign out_x_o    = res_q[0];
  assign out_y_o    = res_q[1];
  assign out_z_o    = res_q[2];
  assign overflow_o = ovf_q;

endmodule

### rtl/affine_point_transform.sv
// ----------------------------------------------------------------------------
// affine_point_transform
// Vertex transform with a 4x3 Q16.16 affine matrix and saturating output.
//
//   channel  | dir | beat contents
//   in_i     | in  | op, coef_row, coef_col, coef_value, point_x/y/z
//   out_o    | out | out_x, out_y, out_z, overflow (transform beats only)
//
// One input beat per cycle while stage one is not held; a transform beat is
// registered in the product, column sum, and translate and saturate stages
// in that order before it is offered on out_o.
// A load beat with coef_col below 3 writes its coefficient at acceptance and
// applies to the next transform beat; it yields no output beat.
// Reset clears all coefficients and empties the pipeline.
// A stall on out_o holds the full stages next to the output; a stage behind a
// bubble keeps advancing, and in_i drops ready once stage one is held.
// ----------------------------------------------------------------------------
module affine_point_transform
  import apt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  apt_in_if.sink    in_i,
  apt_out_if.source out_o
);

  coef_wr_t   coef_wr;
  coef_t      coef [NUM_COEF];
  logic       in_ready;
  logic       is_xform;
  logic       prod_valid, prod_ready;
  prod_beat_t prod_beat;
  logic       psum_valid, psum_ready;
  psum_beat_t psum_beat;

  assign is_xform    = (in_i.op == OP_XFORM);
  assign in_i.ready  = in_ready;

  assign coef_wr.en    = in_i.valid && in_ready && !is_xform
                      && (in_i.coef_col < COL_W'(NUM_COLS));
  assign coef_wr.idx   = IDX_W'(in_i.coef_row) * IDX_W'(NUM_COLS) + IDX_W'(in_i.coef_col);
  assign coef_wr.value = in_i.coef_value;

  apt_coef_bank u_coef_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (coef_wr),
    .coef_o (coef)
  );

  apt_product_stage u_product (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid && is_xform),
    .ready_o   (in_ready),
    .point_x_i (in_i.point_x),
    .point_y_i (in_i.point_y),
    .point_z_i (in_i.point_z),
    .coef_i    (coef),
    .valid_o   (prod_valid),
    .ready_i   (prod_ready),
    .beat_o    (prod_beat)
  );

  apt_accum_stage u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .beat_i  (prod_beat),
    .valid_o (psum_valid),
    .ready_i (psum_ready),
    .beat_o  (psum_beat)
  );

  apt_sat_stage u_sat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (psum_valid),
    .ready_o    (psum_ready),
    .beat_i     (psum_beat),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .out_x_o    (out_o.out_x),
    .out_y_o    (out_o.out_y),
    .out_z_o    (out_o.out_z),
    .overflow_o (out_o.overflow)
  );

endmodule

### rtl/apt_checker.sv
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks of the affine point transform, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apt_checker
  import apt_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  in_op_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input coef_t out_x_i,
  input coef_t out_y_i,
  input coef_t out_z_i,
  input logic  overflow_i
);

  // a stalled result beat keeps out_valid high
  `APT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a transform beat reaches the output through the product, column sum and saturate stages while out_ready stays high
  `APT_ASSERT_NEXT(a_xform_latency, clk_i, rst_ni, (in_valid_i && in_ready_i && in_op_i == OP_XFORM && out_ready_i) ##1 out_ready_i ##1 out_ready_i, out_valid_i)

  // overflow implies at least one clamped coordinate
  `APT_ASSERT_SAME(a_ovf_clamped, clk_i, rst_ni, out_valid_i && overflow_i, out_x_i == SAT_MAX || out_x_i == SAT_MIN || out_y_i == SAT_MAX || out_y_i == SAT_MIN || out_z_i == SAT_MAX || out_z_i == SAT_MIN)

endmodule

bind affine_point_transform apt_checker u_apt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.out_x),
  .out_y_i     (out_o.out_y),
  .out_z_i     (out_o.out_z),
  .overflow_i  (out_o.overflow)
);
